@@ rtl/rcs_pkg.sv @@
// Package for the channel scan controller: operation codes, register indexes,
// the configuration bundle and the shared widths. It depends on nothing else.
`timescale 1ns / 1ps

package rcs_pkg;

   localparam int MAX_CHANNELS = 4;
   localparam int FREQ_REGS    = 4;
   localparam int USED_MAX     = (MAX_CHANNELS < FREQ_REGS) ? MAX_CHANNELS : FREQ_REGS;

   localparam int CHAN_W  = 2;
   localparam int COUNT_W = 3;
   localparam int FREQ_W  = 30;
   localparam int DBM_W   = 8;
   localparam int DWELL_W = 16;
   localparam int TIME_W  = 32;
   localparam int ALERT_W = 16;
   localparam int INDEX_W = 3;

   typedef enum logic [1:0] {
      OP_TICK      = 2'd0,
      OP_CLEAR     = 2'd1,
      OP_STEP_DOWN = 2'd2,
      OP_STEP_UP   = 2'd3
   } op_type;

   typedef enum logic [INDEX_W-1:0] {
      REG_THRESHOLD = 3'd0,
      REG_DWELL     = 3'd1,
      REG_COUNT     = 3'd2,
      REG_FREQ_0    = 3'd3,
      REG_FREQ_1    = 3'd4,
      REG_FREQ_2    = 3'd5,
      REG_FREQ_3    = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [DBM_W-1:0]               threshold;
      logic [DWELL_W-1:0]             dwell;
      logic [COUNT_W-1:0]             count;
      logic [FREQ_REGS-1:0][FREQ_W-1:0] freq;
   } cfg_type;

   localparam logic [DBM_W-1:0]   RST_THRESHOLD = 8'hB5;
   localparam logic [DWELL_W-1:0] RST_DWELL     = 16'd300;
   localparam logic [COUNT_W-1:0] RST_COUNT     = 3'd3;
   localparam logic [FREQ_W-1:0]  RST_FREQ_0    = 30'd315000000;
   localparam logic [FREQ_W-1:0]  RST_FREQ_1    = 30'd433920000;
   localparam logic [FREQ_W-1:0]  RST_FREQ_2    = 30'd868350000;
   localparam logic [FREQ_W-1:0]  RST_FREQ_3    = 30'd0;
   localparam logic [DBM_W-1:0]   RST_DBM       = 8'h88;

endpackage

@@ rtl/rcs_csr.sv @@
// Configuration registers of the channel scan controller.
// Depends on rcs_pkg for the register indexes, widths and reset values.
`timescale 1ns / 1ps

module rcs_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [rcs_pkg::INDEX_W-1:0]  csr_index,
   input  logic [rcs_pkg::FREQ_W-1:0]   csr_write_data,
   output rcs_pkg::cfg_type             cfg
);

   rcs_pkg::cfg_type cfg_ff;
   rcs_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            rcs_pkg::REG_THRESHOLD: cfg_in.threshold = csr_write_data[rcs_pkg::DBM_W-1:0];
            rcs_pkg::REG_DWELL:     cfg_in.dwell     = csr_write_data[rcs_pkg::DWELL_W-1:0];
            rcs_pkg::REG_COUNT:     cfg_in.count     = csr_write_data[rcs_pkg::COUNT_W-1:0];
            rcs_pkg::REG_FREQ_0:    cfg_in.freq[0]   = csr_write_data;
            rcs_pkg::REG_FREQ_1:    cfg_in.freq[1]   = csr_write_data;
            rcs_pkg::REG_FREQ_2:    cfg_in.freq[2]   = csr_write_data;
            rcs_pkg::REG_FREQ_3:    cfg_in.freq[3]   = csr_write_data;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= rcs_pkg::RST_THRESHOLD;
         cfg_ff.dwell     <= rcs_pkg::RST_DWELL;
         cfg_ff.count     <= rcs_pkg::RST_COUNT;
         cfg_ff.freq[0]   <= rcs_pkg::RST_FREQ_0;
         cfg_ff.freq[1]   <= rcs_pkg::RST_FREQ_1;
         cfg_ff.freq[2]   <= rcs_pkg::RST_FREQ_2;
         cfg_ff.freq[3]   <= rcs_pkg::RST_FREQ_3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/rcs_core.sv @@
// Scan state, input register and result register of the channel scan controller.
// Depends on rcs_pkg for the operation codes, widths and the configuration bundle.
`timescale 1ns / 1ps

module rcs_core (
   input  logic                                clock,
   input  logic                                reset,
   input  rcs_pkg::cfg_type                    cfg,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_operation,
   input  logic signed [rcs_pkg::DBM_W-1:0]    req_sample_dbm,
   input  logic [rcs_pkg::TIME_W-1:0]          req_now_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rcs_pkg::CHAN_W-1:0]          rsp_channel,
   output logic [rcs_pkg::FREQ_W-1:0]          rsp_frequency_hz,
   output logic                                rsp_retune,
   output logic                                rsp_scanning,
   output logic [rcs_pkg::ALERT_W-1:0]         rsp_alert_count,
   output logic signed [rcs_pkg::DBM_W-1:0]    rsp_current_dbm,
   output logic signed [rcs_pkg::DBM_W-1:0]    rsp_peak_dbm
);

   localparam logic [rcs_pkg::COUNT_W-1:0] UsedMax = rcs_pkg::COUNT_W'(rcs_pkg::USED_MAX);

   logic                                in_valid_ff;
   rcs_pkg::op_type                     op_ff;
   logic signed [rcs_pkg::DBM_W-1:0]    sample_ff;
   logic [rcs_pkg::TIME_W-1:0]          now_ff;

   logic [rcs_pkg::CHAN_W-1:0]          chan_ff, chan_in;
   logic                                scan_ff, scan_in;
   logic [rcs_pkg::ALERT_W-1:0]         alerts_ff, alerts_in;
   logic signed [rcs_pkg::DBM_W-1:0]    last_ff, last_in;
   logic signed [rcs_pkg::DBM_W-1:0]    peak_ff, peak_in;
   logic [rcs_pkg::TIME_W-1:0]          hop_ff, hop_in;
   logic                                retune_in;

   logic                                out_valid_ff;
   logic [rcs_pkg::CHAN_W-1:0]          out_chan_ff;
   logic [rcs_pkg::FREQ_W-1:0]          out_freq_ff;
   logic                                out_retune_ff;
   logic                                out_scan_ff;
   logic [rcs_pkg::ALERT_W-1:0]         out_alerts_ff;
   logic signed [rcs_pkg::DBM_W-1:0]    out_last_ff;
   logic signed [rcs_pkg::DBM_W-1:0]    out_peak_ff;

   logic                                advance;
   logic [rcs_pkg::COUNT_W-1:0]         used;
   logic [rcs_pkg::COUNT_W-1:0]         chan_wide;
   logic [rcs_pkg::COUNT_W-1:0]         chan_plus;
   logic [rcs_pkg::CHAN_W-1:0]          chan_next;
   logic [rcs_pkg::CHAN_W-1:0]          chan_prev;
   logic [rcs_pkg::TIME_W-1:0]          elapsed;
   logic signed [rcs_pkg::DBM_W-1:0]    threshold;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign threshold = $signed(cfg.threshold);

   always_comb begin
      if (cfg.count == '0) begin
         used = rcs_pkg::COUNT_W'(1);
      end else if (cfg.count > UsedMax) begin
         used = UsedMax;
      end else begin
         used = cfg.count;
      end
      chan_wide = {1'b0, chan_ff};
      chan_plus = chan_wide + rcs_pkg::COUNT_W'(1);
      chan_next = (chan_plus >= used) ? '0 : chan_plus[rcs_pkg::CHAN_W-1:0];
      if (chan_ff == '0 || chan_wide >= used) begin
         chan_prev = rcs_pkg::CHAN_W'(used - rcs_pkg::COUNT_W'(1));
      end else begin
         chan_prev = chan_ff - rcs_pkg::CHAN_W'(1);
      end
      elapsed = now_ff - hop_ff;
   end

   always_comb begin
      chan_in   = chan_ff;
      scan_in   = scan_ff;
      alerts_in = alerts_ff;
      last_in   = last_ff;
      peak_in   = peak_ff;
      hop_in    = hop_ff;
      retune_in = 1'b0;
      case (op_ff)
         rcs_pkg::OP_TICK: begin
            last_in = sample_ff;
            if (sample_ff > peak_ff) begin
               peak_in = sample_ff;
            end
            if (sample_ff > threshold) begin
               if (scan_ff) begin
                  if (alerts_ff != '1) begin
                     alerts_in = alerts_ff + rcs_pkg::ALERT_W'(1);
                  end
                  scan_in = 1'b0;
               end
            end else if (scan_ff && elapsed > rcs_pkg::TIME_W'(cfg.dwell)) begin
               chan_in   = chan_next;
               hop_in    = now_ff;
               retune_in = 1'b1;
            end
         end
         rcs_pkg::OP_CLEAR: begin
            alerts_in = '0;
            peak_in   = $signed(rcs_pkg::RST_DBM);
            scan_in   = 1'b1;
         end
         rcs_pkg::OP_STEP_DOWN: begin
            scan_in   = 1'b0;
            chan_in   = chan_prev;
            retune_in = 1'b1;
         end
         rcs_pkg::OP_STEP_UP: begin
            scan_in   = 1'b0;
            chan_in   = chan_next;
            retune_in = 1'b1;
         end
         default: begin
            chan_in = chan_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         chan_ff      <= '0;
         scan_ff      <= 1'b1;
         alerts_ff    <= '0;
         last_ff      <= $signed(rcs_pkg::RST_DBM);
         peak_ff      <= $signed(rcs_pkg::RST_DBM);
         hop_ff       <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (advance) begin
            chan_ff   <= chan_in;
            scan_ff   <= scan_in;
            alerts_ff <= alerts_in;
            last_ff   <= last_in;
            peak_ff   <= peak_in;
            hop_ff    <= hop_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff     <= rcs_pkg::op_type'(req_operation);
         sample_ff <= req_sample_dbm;
         now_ff    <= req_now_ms;
      end
      if (advance) begin
         out_chan_ff   <= chan_in;
         out_freq_ff   <= cfg.freq[chan_in];
         out_retune_ff <= retune_in;
         out_scan_ff   <= scan_in;
         out_alerts_ff <= alerts_in;
         out_last_ff   <= last_in;
         out_peak_ff   <= peak_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_channel      = out_chan_ff;
   assign rsp_frequency_hz = out_freq_ff;
   assign rsp_retune       = out_retune_ff;
   assign rsp_scanning     = out_scan_ff;
   assign rsp_alert_count  = out_alerts_ff;
   assign rsp_current_dbm  = out_last_ff;
   assign rsp_peak_dbm     = out_peak_ff;

endmodule

@@ rtl/rssi_channel_scan_controller_top.sv @@
// Top level of the channel scan controller: configuration registers and scan core.
// Depends on rcs_pkg, rcs_csr and rcs_core.
// A word accepted goes to the input register, then to the result register once that is free.
// Throughput: one word per cycle while rsp_ready is high; a result frees as it is taken.
// Reset: synchronous; configuration and scan state return to their defaults, both ports empty.
`timescale 1ns / 1ps

module rssi_channel_scan_controller_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [rcs_pkg::INDEX_W-1:0]         csr_index,
   input  logic [rcs_pkg::FREQ_W-1:0]          csr_write_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_operation,
   input  logic signed [rcs_pkg::DBM_W-1:0]    req_sample_dbm,
   input  logic [rcs_pkg::TIME_W-1:0]          req_now_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rcs_pkg::CHAN_W-1:0]          rsp_channel,
   output logic [rcs_pkg::FREQ_W-1:0]          rsp_frequency_hz,
   output logic                                rsp_retune,
   output logic                                rsp_scanning,
   output logic [rcs_pkg::ALERT_W-1:0]         rsp_alert_count,
   output logic signed [rcs_pkg::DBM_W-1:0]    rsp_current_dbm,
   output logic signed [rcs_pkg::DBM_W-1:0]    rsp_peak_dbm
);

   rcs_pkg::cfg_type cfg;

   rcs_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   rcs_core u_core (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_sample_dbm   (req_sample_dbm),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_channel      (rsp_channel),
      .rsp_frequency_hz (rsp_frequency_hz),
      .rsp_retune       (rsp_retune),
      .rsp_scanning     (rsp_scanning),
      .rsp_alert_count  (rsp_alert_count),
      .rsp_current_dbm  (rsp_current_dbm),
      .rsp_peak_dbm     (rsp_peak_dbm)
   );

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the channel scan controller: a directed table of words,
// then random phases with varied register settings and handshake idling.
// Depends on rcs_pkg and rssi_channel_scan_controller_top.
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int PHASES          = 8;
   localparam int WORDS_PER_PHASE = 75;
   localparam int PRESSURE_PHASE  = 4;
   localparam int HOLD_CYCLES     = 400;
   localparam int REPORT_LIMIT    = 10;
   localparam int DRAIN_CYCLES    = 8;

   typedef struct packed {
      logic [rcs_pkg::CHAN_W-1:0]  channel;
      logic [rcs_pkg::FREQ_W-1:0]  frequency_hz;
      logic                        retune;
      logic                        scanning;
      logic [rcs_pkg::ALERT_W-1:0] alert_count;
      logic [rcs_pkg::DBM_W-1:0]   current_dbm;
      logic [rcs_pkg::DBM_W-1:0]   peak_dbm;
   } scan_status_type;

   typedef struct {
      bit                               is_csr;
      rcs_pkg::reg_index_type           reg_index;
      logic [rcs_pkg::FREQ_W-1:0]       reg_data;
      rcs_pkg::op_type                  operation;
      logic signed [rcs_pkg::DBM_W-1:0] sample_dbm;
      logic [rcs_pkg::TIME_W-1:0]       now_ms;
      bit                               typed;
      scan_status_type                  status;
   } plan_row_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             csr_write_enable;
   logic [rcs_pkg::INDEX_W-1:0]      csr_index;
   logic [rcs_pkg::FREQ_W-1:0]       csr_write_data;
   logic                             req_valid;
   logic                             req_ready;
   logic [1:0]                       req_operation;
   logic signed [rcs_pkg::DBM_W-1:0] req_sample_dbm;
   logic [rcs_pkg::TIME_W-1:0]       req_now_ms;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic [rcs_pkg::CHAN_W-1:0]       rsp_channel;
   logic [rcs_pkg::FREQ_W-1:0]       rsp_frequency_hz;
   logic                             rsp_retune;
   logic                             rsp_scanning;
   logic [rcs_pkg::ALERT_W-1:0]      rsp_alert_count;
   logic signed [rcs_pkg::DBM_W-1:0] rsp_current_dbm;
   logic signed [rcs_pkg::DBM_W-1:0] rsp_peak_dbm;

   logic signed [rcs_pkg::DBM_W-1:0] shadow_threshold;
   logic [rcs_pkg::DWELL_W-1:0]      shadow_dwell;
   logic [rcs_pkg::COUNT_W-1:0]      shadow_count;
   logic [rcs_pkg::FREQ_W-1:0]       shadow_freq [rcs_pkg::FREQ_REGS];
   logic [rcs_pkg::CHAN_W-1:0]       shadow_channel;
   logic                             shadow_scanning;
   logic [rcs_pkg::ALERT_W-1:0]      shadow_alerts;
   logic signed [rcs_pkg::DBM_W-1:0] shadow_current;
   logic signed [rcs_pkg::DBM_W-1:0] shadow_peak;
   logic [rcs_pkg::TIME_W-1:0]       shadow_hop_ms;

   scan_status_type pending_status_q [$];
   plan_row_type    plan_q [$];
   int              send_idle_pct  = 0;
   int              recv_stall_pct = 0;
   int              hold_requests  = 0;
   int              fail_count     = 0;
   int              cycle_count    = 0;

   rssi_channel_scan_controller_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_sample_dbm   (req_sample_dbm),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_channel      (rsp_channel),
      .rsp_frequency_hz (rsp_frequency_hz),
      .rsp_retune       (rsp_retune),
      .rsp_scanning     (rsp_scanning),
      .rsp_alert_count  (rsp_alert_count),
      .rsp_current_dbm  (rsp_current_dbm),
      .rsp_peak_dbm     (rsp_peak_dbm)
   );

   always #2 clock = ~clock;

   function automatic int channels_in_use();
      int n;
      n = int'(shadow_count);
      if (n == 0) n = 1;
      if (n > rcs_pkg::USED_MAX) n = rcs_pkg::USED_MAX;
      return n;
   endfunction

   function automatic logic [rcs_pkg::CHAN_W-1:0] channel_after(int n);
      return (int'(shadow_channel) + 1 >= n) ? '0 : shadow_channel + 1'b1;
   endfunction

   function automatic scan_status_type predict_scan(rcs_pkg::op_type op,
                                                    logic signed [rcs_pkg::DBM_W-1:0] level,
                                                    logic [rcs_pkg::TIME_W-1:0] stamp);
      int                         n;
      logic                       retune;
      logic [rcs_pkg::TIME_W-1:0] elapsed;
      n = channels_in_use();
      retune = 1'b0;
      elapsed = stamp - shadow_hop_ms;
      case (op)
         rcs_pkg::OP_TICK: begin
            shadow_current = level;
            if (level > shadow_peak) shadow_peak = level;
            if (level > shadow_threshold) begin
               if (shadow_scanning) begin
                  if (shadow_alerts != '1) shadow_alerts = shadow_alerts + 1'b1;
                  shadow_scanning = 1'b0;
               end
            end else if (shadow_scanning && elapsed > rcs_pkg::TIME_W'(shadow_dwell)) begin
               shadow_channel = channel_after(n);
               shadow_hop_ms = stamp;
               retune = 1'b1;
            end
         end
         rcs_pkg::OP_CLEAR: begin
            shadow_alerts = '0;
            shadow_peak = rcs_pkg::RST_DBM;
            shadow_scanning = 1'b1;
         end
         rcs_pkg::OP_STEP_DOWN: begin
            shadow_scanning = 1'b0;
            if (shadow_channel == 0 || int'(shadow_channel) >= n) begin
               shadow_channel = rcs_pkg::CHAN_W'(n - 1);
            end else begin
               shadow_channel = shadow_channel - 1'b1;
            end
            retune = 1'b1;
         end
         default: begin
            shadow_scanning = 1'b0;
            shadow_channel = channel_after(n);
            retune = 1'b1;
         end
      endcase
      return '{shadow_channel, shadow_freq[shadow_channel], retune, shadow_scanning,
               shadow_alerts, shadow_current, shadow_peak};
   endfunction

   function automatic string status_text(scan_status_type s);
      return $sformatf("ch %0d freq %0d retune %0d scan %0d alerts %0d cur %0d peak %0d",
                       s.channel, s.frequency_hz, s.retune, s.scanning, s.alert_count,
                       $signed(s.current_dbm), $signed(s.peak_dbm));
   endfunction

   function automatic plan_row_type plan_csr(rcs_pkg::reg_index_type idx,
                                             logic [rcs_pkg::FREQ_W-1:0] data);
      plan_row_type row;
      row.is_csr = 1'b1;
      row.reg_index = idx;
      row.reg_data = data;
      row.typed = 1'b0;
      return row;
   endfunction

   function automatic plan_row_type plan_item(rcs_pkg::op_type op,
                                              logic signed [rcs_pkg::DBM_W-1:0] level,
                                              logic [rcs_pkg::TIME_W-1:0] stamp);
      plan_row_type row;
      row.is_csr = 1'b0;
      row.operation = op;
      row.sample_dbm = level;
      row.now_ms = stamp;
      row.typed = 1'b0;
      return row;
   endfunction

   function automatic plan_row_type plan_checked(rcs_pkg::op_type op,
                                                 logic signed [rcs_pkg::DBM_W-1:0] level,
                                                 logic [rcs_pkg::TIME_W-1:0] stamp,
                                                 logic [rcs_pkg::CHAN_W-1:0] ch,
                                                 logic [rcs_pkg::FREQ_W-1:0] freq,
                                                 logic rt, logic sc,
                                                 logic [rcs_pkg::ALERT_W-1:0] al,
                                                 logic [rcs_pkg::DBM_W-1:0] cur,
                                                 logic [rcs_pkg::DBM_W-1:0] pk);
      plan_row_type row;
      row = plan_item(op, level, stamp);
      row.typed = 1'b1;
      row.status = '{ch, freq, rt, sc, al, cur, pk};
      return row;
   endfunction

   task automatic csr_write(rcs_pkg::reg_index_type idx, logic [rcs_pkg::FREQ_W-1:0] data);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      case (idx)
         rcs_pkg::REG_THRESHOLD: shadow_threshold = data[rcs_pkg::DBM_W-1:0];
         rcs_pkg::REG_DWELL:     shadow_dwell = data[rcs_pkg::DWELL_W-1:0];
         rcs_pkg::REG_COUNT:     shadow_count = data[rcs_pkg::COUNT_W-1:0];
         default:                shadow_freq[2'(idx - rcs_pkg::REG_FREQ_0)] = data;
      endcase
      @(negedge clock);
   endtask

   task automatic send_word(rcs_pkg::op_type op, logic signed [rcs_pkg::DBM_W-1:0] level,
                            logic [rcs_pkg::TIME_W-1:0] stamp, bit typed,
                            scan_status_type status);
      scan_status_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_operation = op;
      req_sample_dbm = level;
      req_now_ms = stamp;
      do @(posedge clock); while (!req_ready);
      predicted = predict_scan(op, level, stamp);
      pending_status_q.push_back(typed ? status : predicted);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_status_q.size() != 0) @(negedge clock);
   endtask

   initial begin
      int                               roll;
      rcs_pkg::op_type                  op;
      logic [rcs_pkg::DBM_W-1:0]        thr;
      logic [rcs_pkg::DWELL_W-1:0]      dwell;
      logic [rcs_pkg::COUNT_W-1:0]      count;
      logic [rcs_pkg::FREQ_W-1:0]       freq [rcs_pkg::FREQ_REGS];
      logic signed [rcs_pkg::DBM_W-1:0] level;
      logic [rcs_pkg::TIME_W-1:0]       stamp;
      logic [rcs_pkg::TIME_W-1:0]       clock_ms;

      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_operation = '0;
      req_sample_dbm = '0;
      req_now_ms = '0;
      clock_ms = '0;

      shadow_threshold = rcs_pkg::RST_THRESHOLD;
      shadow_dwell = rcs_pkg::RST_DWELL;
      shadow_count = rcs_pkg::RST_COUNT;
      shadow_freq[0] = rcs_pkg::RST_FREQ_0;
      shadow_freq[1] = rcs_pkg::RST_FREQ_1;
      shadow_freq[2] = rcs_pkg::RST_FREQ_2;
      shadow_freq[3] = rcs_pkg::RST_FREQ_3;
      shadow_channel = '0;
      shadow_scanning = 1'b1;
      shadow_alerts = '0;
      shadow_current = rcs_pkg::RST_DBM;
      shadow_peak = rcs_pkg::RST_DBM;
      shadow_hop_ms = '0;

      // Rows up to the second clear run on the settings from reset.
      plan_q.push_back(plan_checked(rcs_pkg::OP_TICK, -8'sd120, 32'd0, 2'd0,
                                    rcs_pkg::RST_FREQ_0, 1'b0, 1'b1, 16'd0, 8'h88, 8'h88));
      plan_q.push_back(plan_checked(rcs_pkg::OP_TICK, -8'sd75, 32'd300, 2'd0,
                                    rcs_pkg::RST_FREQ_0, 1'b0, 1'b1, 16'd0, -8'sd75, -8'sd75));
      plan_q.push_back(plan_checked(rcs_pkg::OP_TICK, -8'sd80, 32'd301, 2'd1,
                                    rcs_pkg::RST_FREQ_1, 1'b1, 1'b1, 16'd0, -8'sd80, -8'sd75));
      plan_q.push_back(plan_checked(rcs_pkg::OP_TICK, -8'sd74, 32'd302, 2'd1,
                                    rcs_pkg::RST_FREQ_1, 1'b0, 1'b0, 16'd1, -8'sd74, -8'sd74));
      plan_q.push_back(plan_checked(rcs_pkg::OP_TICK, 8'sh7f, 32'd1000, 2'd1,
                                    rcs_pkg::RST_FREQ_1, 1'b0, 1'b0, 16'd1, 8'h7f, 8'h7f));
      plan_q.push_back(plan_checked(rcs_pkg::OP_TICK, 8'sh80, 32'd2000, 2'd1,
                                    rcs_pkg::RST_FREQ_1, 1'b0, 1'b0, 16'd1, 8'h80, 8'h7f));
      plan_q.push_back(plan_checked(rcs_pkg::OP_CLEAR, 8'sh00, 32'd0, 2'd1,
                                    rcs_pkg::RST_FREQ_1, 1'b0, 1'b1, 16'd0, 8'h80, 8'h88));
      plan_q.push_back(plan_checked(rcs_pkg::OP_STEP_UP, 8'sh00, 32'd0, 2'd2,
                                    rcs_pkg::RST_FREQ_2, 1'b1, 1'b0, 16'd0, 8'h80, 8'h88));
      plan_q.push_back(plan_checked(rcs_pkg::OP_STEP_UP, 8'sh00, 32'd0, 2'd0,
                                    rcs_pkg::RST_FREQ_0, 1'b1, 1'b0, 16'd0, 8'h80, 8'h88));
      plan_q.push_back(plan_checked(rcs_pkg::OP_STEP_DOWN, 8'sh00, 32'd0, 2'd2,
                                    rcs_pkg::RST_FREQ_2, 1'b1, 1'b0, 16'd0, 8'h80, 8'h88));
      plan_q.push_back(plan_checked(rcs_pkg::OP_STEP_DOWN, 8'sh00, 32'd0, 2'd1,
                                    rcs_pkg::RST_FREQ_1, 1'b1, 1'b0, 16'd0, 8'h80, 8'h88));
      plan_q.push_back(plan_checked(rcs_pkg::OP_CLEAR, 8'sh00, 32'd0, 2'd1,
                                    rcs_pkg::RST_FREQ_1, 1'b0, 1'b1, 16'd0, 8'h80, 8'h88));
      // Elapsed time exactly at the dwell, then across the wrap of the millisecond timer.
      plan_q.push_back(plan_item(rcs_pkg::OP_TICK, -8'sd100, 32'd601));
      plan_q.push_back(plan_item(rcs_pkg::OP_TICK, -8'sd100, 32'hffff_ffff));
      plan_q.push_back(plan_item(rcs_pkg::OP_TICK, -8'sd100, 32'd300));
      plan_q.push_back(plan_item(rcs_pkg::OP_STEP_UP, 8'sh55, 32'h5555_5555));
      plan_q.push_back(plan_item(rcs_pkg::OP_STEP_UP, 8'sh2a, 32'haaaa_aaaa));
      // The stored channel now lies beyond the number of channels in use.
      plan_q.push_back(plan_csr(rcs_pkg::REG_COUNT, 30'd2));
      plan_q.push_back(plan_item(rcs_pkg::OP_TICK, 8'sh80, 32'd5000));
      plan_q.push_back(plan_item(rcs_pkg::OP_CLEAR, 8'sh00, 32'd0));
      plan_q.push_back(plan_item(rcs_pkg::OP_TICK, 8'sh80, 32'd9000));
      plan_q.push_back(plan_csr(rcs_pkg::REG_COUNT, 30'd3));
      plan_q.push_back(plan_item(rcs_pkg::OP_STEP_DOWN, 8'sh00, 32'd0));
      plan_q.push_back(plan_csr(rcs_pkg::REG_COUNT, 30'd2));
      plan_q.push_back(plan_item(rcs_pkg::OP_STEP_DOWN, 8'sh00, 32'd0));
      plan_q.push_back(plan_csr(rcs_pkg::REG_COUNT, 30'd3));
      plan_q.push_back(plan_item(rcs_pkg::OP_STEP_UP, 8'sh00, 32'd0));
      plan_q.push_back(plan_csr(rcs_pkg::REG_COUNT, 30'd2));
      plan_q.push_back(plan_item(rcs_pkg::OP_STEP_UP, 8'sh00, 32'd0));
      plan_q.push_back(plan_csr(rcs_pkg::REG_COUNT, 30'd0));
      plan_q.push_back(plan_item(rcs_pkg::OP_STEP_UP, 8'sh00, 32'd0));
      plan_q.push_back(plan_csr(rcs_pkg::REG_COUNT, 30'd7));
      plan_q.push_back(plan_item(rcs_pkg::OP_STEP_DOWN, 8'sh00, 32'd0));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < plan_q.size(); r++) begin
         if (plan_q[r].is_csr) begin
            wait_drained();
            csr_write(plan_q[r].reg_index, plan_q[r].reg_data);
            if (r == plan_q.size() - 1 || !plan_q[r + 1].is_csr) csr_write_enable = 1'b0;
         end else begin
            send_word(plan_q[r].operation, plan_q[r].sample_dbm, plan_q[r].now_ms,
                      plan_q[r].typed, plan_q[r].status);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         thr = (ph == 1) ? 8'h80 : (ph == 2) ? 8'h7f :
               rcs_pkg::DBM_W'($urandom_range(0, 255));
         dwell = (ph == 3) ? 16'd0 : (ph == 4) ? 16'hffff :
                 rcs_pkg::DWELL_W'($urandom_range(0, 600));
         count = (ph == 5) ? 3'd4 : (ph == 6) ? 3'd1 :
                 rcs_pkg::COUNT_W'($urandom_range(0, 7));
         for (int f = 0; f < rcs_pkg::FREQ_REGS; f++) begin
            freq[f] = (ph == 2) ? 30'd0 : (ph == 3) ? 30'd1000000000 :
                      rcs_pkg::FREQ_W'($urandom_range(0, 1000000000));
         end
         csr_write(rcs_pkg::REG_THRESHOLD, rcs_pkg::FREQ_W'(thr));
         csr_write(rcs_pkg::REG_DWELL, rcs_pkg::FREQ_W'(dwell));
         csr_write(rcs_pkg::REG_COUNT, rcs_pkg::FREQ_W'(count));
         for (int f = 0; f < rcs_pkg::FREQ_REGS; f++) begin
            csr_write(rcs_pkg::reg_index_type'(rcs_pkg::REG_FREQ_0 + f), freq[f]);
         end
         csr_write_enable = 1'b0;

         send_idle_pct  = (ph % 4 == 1) ? 85 : (ph % 4 == 3) ? 28 : 0;
         recv_stall_pct = (ph % 4 == 2) ? 85 : (ph % 4 == 3) ? 28 : 0;
         // The receiver holds off for a long stretch while words keep coming.
         if (ph == PRESSURE_PHASE) hold_requests++;

         for (int k = 0; k < WORDS_PER_PHASE; k++) begin
            roll = $urandom_range(99);
            op = (roll < 68) ? rcs_pkg::OP_TICK : (roll < 80) ? rcs_pkg::OP_CLEAR :
                 (roll < 90) ? rcs_pkg::OP_STEP_DOWN : rcs_pkg::OP_STEP_UP;
            level = rcs_pkg::DBM_W'($urandom());
            stamp = $urandom();
            if (op == rcs_pkg::OP_TICK) begin
               roll = $urandom_range(99);
               if (roll < 50) begin
                  level = rcs_pkg::DBM_W'(int'(shadow_threshold) +
                                          int'($urandom_range(0, 6)) - 3);
               end else if (roll >= 75) begin
                  level = rcs_pkg::DBM_W'(int'(shadow_threshold) -
                                          int'($urandom_range(1, 20)));
               end
               roll = $urandom_range(99);
               if (roll < 20) begin
                  stamp = shadow_hop_ms + shadow_dwell + $urandom_range(0, 1);
               end else if (roll >= 30) begin
                  stamp = clock_ms + $urandom_range(0, 2 * int'(shadow_dwell) + 2);
               end
               clock_ms = stamp;
            end
            send_word(op, level, stamp, 1'b0, '0);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_status_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      int hold_left;
      int holds_served;
      hold_left = 0;
      holds_served = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : result_check
      scan_status_type seen;
      scan_status_type want;
      seen = '{rsp_channel, rsp_frequency_hz, rsp_retune, rsp_scanning, rsp_alert_count,
               rsp_current_dbm, rsp_peak_dbm};
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_status_q.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
               $display("unexpected result word: %s", status_text(seen));
            end
         end else begin
            want = pending_status_q.pop_front();
            if (seen.channel !== want.channel || seen.frequency_hz !== want.frequency_hz ||
                seen.retune !== want.retune || seen.scanning !== want.scanning ||
                seen.alert_count !== want.alert_count ||
                seen.current_dbm !== want.current_dbm || seen.peak_dbm !== want.peak_dbm) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("result mismatch: expected %s", status_text(want));
                  $display("                 actual   %s", status_text(seen));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule
